>>> rtl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants of the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

  // ray parameter width, unsigned q8.16
  localparam int unsigned TW     = 24;
  localparam logic [TW-1:0] TSat = 24'hFFFFFF;

  // divider operand widths: dist * len and |d| * 64
  localparam int unsigned NumW = 39;
  localparam int unsigned DenW = 22;

  // integer square root of s << 28
  localparam int unsigned SqW  = 60;
  localparam int unsigned LenW = 30;

  localparam int unsigned RadW = 5;
  localparam logic [RadW-1:0] RadReset = 5'd6;

  // step sign codes, also used for the face normal
  localparam logic [1:0] StepZero = 2'b00;
  localparam logic [1:0] StepPos  = 2'b01;
  localparam logic [1:0] StepNeg  = 2'b11;

  typedef struct packed {
    logic [1:0]    step;
    logic [TW-1:0] tmax;
    logic [TW-1:0] tdelta;
  } axis_t;

  typedef enum logic [2:0] {
    FeIdle, FeSquare, FeSum, FeSqrt, FeMul, FeDivStart, FeDivWait, FePush
  } fe_state_e;

  typedef enum logic {
    BeIdle, BeRun
  } be_state_e;

endpackage

>>> rtl/vrt_if.sv
// ----------------------------------------------------------------------------
// vrt_if
// Valid/ready channels for rays in and traversed cells out.
// ----------------------------------------------------------------------------
interface vrt_ray_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic signed [23:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface vrt_cell_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cell_x;
  logic signed [15:0] cell_y;
  logic signed [15:0] cell_z;
  logic signed [1:0]  normal_x;
  logic signed [1:0]  normal_y;
  logic signed [1:0]  normal_z;
  logic               cell_valid;
  logic               last;

  modport source (output valid, cell_x, cell_y, cell_z, normal_x, normal_y, normal_z,
                  cell_valid, last, input ready);
  modport sink (input valid, cell_x, cell_y, cell_z, normal_x, normal_y, normal_z,
                cell_valid, last, output ready);
endinterface

>>> rtl/vrt_div.sv
// ----------------------------------------------------------------------------
// vrt_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 24 bits.
// ----------------------------------------------------------------------------
module vrt_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vrt_pkg::NumW-1:0]    num_i,
  input  logic [vrt_pkg::DenW-1:0]    den_i,
  output logic                        done_o,
  output logic [vrt_pkg::TW-1:0]      quo_o
);
  localparam int unsigned ShW  = vrt_pkg::DenW + vrt_pkg::TW;
  localparam int unsigned CntW = $clog2(vrt_pkg::TW);

  logic [vrt_pkg::NumW-1:0] rem_q;
  logic [ShW-1:0]           dsh_q;
  logic [vrt_pkg::TW-1:0]   quo_q;
  logic [CntW-1:0]          cnt_q;
  logic                     busy_q, done_q;
  logic                     sat, ge;

  // zero divisor also lands here, which saturates an axis with no motion
  assign sat = {{(ShW-vrt_pkg::NumW){1'b0}}, num_i} >= {den_i, {vrt_pkg::TW{1'b0}}};
  assign ge  = {{(ShW-vrt_pkg::NumW){1'b0}}, rem_q} >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsh_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      if (sat) begin
        quo_q  <= vrt_pkg::TSat;
        done_q <= 1'b1;
        busy_q <= 1'b0;
      end else begin
        rem_q  <= num_i;
        dsh_q  <= {1'b0, den_i, {(vrt_pkg::TW-1){1'b0}}};
        quo_q  <= '0;
        cnt_q  <= CntW'(vrt_pkg::TW - 1);
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - vrt_pkg::NumW'(dsh_q);
      end
      quo_q <= {quo_q[vrt_pkg::TW-2:0], ge};
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

>>> rtl/vrt_front.sv
// ----------------------------------------------------------------------------
// vrt_front
// Accepts a ray and sets up start cell, step signs, tMax and tDelta per axis.
// ----------------------------------------------------------------------------
module vrt_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  vrt_ray_if.sink                       ray,
  output vrt_pkg::axis_t [2:0]          axes_o,
  output logic [3*COORD_BITS-1:0]       cells_o,
  output logic                          push_o,
  input  logic                          full_i
);
  localparam int unsigned ExtW = (COORD_BITS > 16) ? COORD_BITS : 16;

  vrt_pkg::fe_state_e state_q, state_d;

  logic signed [15:0]          dir_q  [3];
  logic [7:0]                  frac_q [3];
  logic [COORD_BITS-1:0]       cell_q [3];
  logic [31:0]                 sq_q   [3];
  logic [vrt_pkg::SqW-1:0]     rem_q, root_q, bit_q, trial;
  logic [vrt_pkg::NumW-1:0]    num_tm_q [3];
  logic [vrt_pkg::NumW-1:0]    num_td;
  logic [vrt_pkg::LenW-1:0]    len;

  logic signed [23:0]          org [3];
  logic signed [15:0]          dir [3];
  logic signed [ExtW-1:0]      fl_ext [3];
  logic [15:0]                 ad [3];
  logic [8:0]                  span [3];
  logic [vrt_pkg::TW-1:0]      q_tm [3], q_td [3];
  logic [5:0]                  div_done;
  logic                        div_start;
  logic                        accept;
  logic [31:0]                 sq_sum;

  assign org[0] = ray.origin_x;
  assign org[1] = ray.origin_y;
  assign org[2] = ray.origin_z;
  assign dir[0] = ray.dir_x;
  assign dir[1] = ray.dir_y;
  assign dir[2] = ray.dir_z;

  assign accept = ray.valid && ray.ready;
  assign len    = root_q[vrt_pkg::LenW-1:0];
  assign num_td = {{(vrt_pkg::NumW-vrt_pkg::LenW-2){1'b0}}, len, 2'b00};
  assign sq_sum = sq_q[0] + sq_q[1] + sq_q[2];
  assign trial  = root_q + bit_q;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign fl_ext[a] = ExtW'($signed(org[a][23:8]));
    assign ad[a]     = dir_q[a][15] ? 16'(-dir_q[a]) : 16'(dir_q[a]);
    always_comb begin
      if (dir_q[a] > 0) begin
        span[a] = (frac_q[a] == 8'd0) ? 9'd256 : 9'd256 - {1'b0, frac_q[a]};
      end else begin
        span[a] = {1'b0, frac_q[a]};
      end
    end

    vrt_div u_div_tm (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (num_tm_q[a]),
      .den_i   ({ad[a], 6'b0}),
      .done_o  (div_done[2*a]),
      .quo_o   (q_tm[a])
    );

    vrt_div u_div_td (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (num_td),
      .den_i   ({6'b0, ad[a]}),
      .done_o  (div_done[2*a+1]),
      .quo_o   (q_td[a])
    );

    always_comb begin
      axes_o[a].tmax   = q_tm[a];
      axes_o[a].tdelta = q_td[a];
      if (dir_q[a] == 16'sd0) begin
        axes_o[a].step = vrt_pkg::StepZero;
      end else if (dir_q[a][15]) begin
        axes_o[a].step = vrt_pkg::StepNeg;
      end else begin
        axes_o[a].step = vrt_pkg::StepPos;
      end
    end
    assign cells_o[a*COORD_BITS +: COORD_BITS] = cell_q[a];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vrt_pkg::FeIdle:     if (accept) state_d = vrt_pkg::FeSquare;
      vrt_pkg::FeSquare:   state_d = vrt_pkg::FeSum;
      vrt_pkg::FeSum:      state_d = vrt_pkg::FeSqrt;
      vrt_pkg::FeSqrt:     if (bit_q == '0) state_d = vrt_pkg::FeMul;
      vrt_pkg::FeMul:      state_d = vrt_pkg::FeDivStart;
      vrt_pkg::FeDivStart: state_d = vrt_pkg::FeDivWait;
      vrt_pkg::FeDivWait:  if (&div_done) state_d = vrt_pkg::FePush;
      vrt_pkg::FePush:     if (!full_i) state_d = vrt_pkg::FeIdle;
      default:             state_d = vrt_pkg::FeIdle;
    endcase
  end

  // outputs
  always_comb begin
    ray.ready = (state_q == vrt_pkg::FeIdle);
    div_start = (state_q == vrt_pkg::FeDivStart);
    push_o    = (state_q == vrt_pkg::FePush) && !full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vrt_pkg::FeIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      vrt_pkg::FeIdle: begin
        if (accept) begin
          for (int a = 0; a < 3; a++) begin
            dir_q[a]  <= dir[a];
            frac_q[a] <= org[a][7:0];
            cell_q[a] <= fl_ext[a][COORD_BITS-1:0];
          end
        end
      end
      vrt_pkg::FeSquare: begin
        for (int a = 0; a < 3; a++) begin
          sq_q[a] <= 32'(dir_q[a] * dir_q[a]);
        end
      end
      vrt_pkg::FeSum: begin
        rem_q  <= {sq_sum, 28'b0};
        root_q <= '0;
        bit_q  <= vrt_pkg::SqW'(1) << 58;
      end
      vrt_pkg::FeSqrt: begin
        if (bit_q != '0) begin
          if (rem_q >= trial) begin
            rem_q  <= rem_q - trial;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
      vrt_pkg::FeMul: begin
        for (int a = 0; a < 3; a++) begin
          num_tm_q[a] <= vrt_pkg::NumW'(span[a]) * vrt_pkg::NumW'(len);
        end
      end
      default: begin
      end
    endcase
  end
endmodule

>>> rtl/vrt_queue.sv
// ----------------------------------------------------------------------------
// vrt_queue
// Two-entry queue of set-up rays between the front and the stepping engine.
// ----------------------------------------------------------------------------
module vrt_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         full_o,
  output logic         empty_o
);
  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
endmodule

>>> rtl/vrt_back.sv
// ----------------------------------------------------------------------------
// vrt_back
// Stepping engine: advances the axis with the smallest tMax, one cell a cycle while the output slot is free.
// ----------------------------------------------------------------------------
module vrt_back #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned MAX_STEPS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vrt_pkg::axis_t [2:0]          axes_i,
  input  logic [3*COORD_BITS-1:0]       cells_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  logic [vrt_pkg::RadW-1:0]      radius_i,
  vrt_cell_if.source                    vox
);
  localparam int unsigned ExtW = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int unsigned CntW = $clog2(MAX_STEPS + 1);

  vrt_pkg::be_state_e state_q, state_d;

  vrt_pkg::axis_t         axis_q [3];
  logic [COORD_BITS-1:0]  cpos_q [3];
  logic [CntW-1:0]        n_q;
  logic                   ovalid_q;
  logic [15:0]            ocell_q [3];
  logic [1:0]             onorm_q [3];
  logic                   ocv_q, olast_q;

  logic [vrt_pkg::TW-1:0] rad, tnew;
  logic [vrt_pkg::TW:0]   tsum;
  logic [1:0]             sel;
  logic                   cont, next_cont, more_steps, slot_free, fire;
  logic [2:0]             hit, hit_next;
  logic [COORD_BITS-1:0]  cnew [3];
  logic [ExtW-1:0]        cext [3];

  assign rad       = {3'b0, radius_i, 16'b0};
  assign slot_free = !ovalid_q || vox.ready;
  assign fire      = (state_q == vrt_pkg::BeRun) && slot_free;

  // ties: x loses to y, both lose to z
  always_comb begin
    if (axis_q[0].tmax < axis_q[1].tmax) begin
      sel = (axis_q[0].tmax < axis_q[2].tmax) ? 2'd0 : 2'd2;
    end else begin
      sel = (axis_q[1].tmax < axis_q[2].tmax) ? 2'd1 : 2'd2;
    end
  end

  assign tsum = {1'b0, axis_q[sel].tmax} + {1'b0, axis_q[sel].tdelta};
  assign tnew = tsum[vrt_pkg::TW] ? vrt_pkg::TSat : tsum[vrt_pkg::TW-1:0];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign hit[a]      = axis_q[a].tmax <= rad;
    assign hit_next[a] = ((sel == 2'(a)) ? tnew : axis_q[a].tmax) <= rad;
    always_comb begin
      cnew[a] = cpos_q[a];
      if (sel == 2'(a)) begin
        cnew[a] = (axis_q[a].step == vrt_pkg::StepPos) ? cpos_q[a] + COORD_BITS'(1)
                                                       : cpos_q[a] - COORD_BITS'(1);
      end
    end
    assign cext[a] = ExtW'(cnew[a]);
  end

  assign cont       = |hit;
  assign more_steps = (n_q + CntW'(1)) < CntW'(MAX_STEPS);
  assign next_cont  = more_steps && (|hit_next);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vrt_pkg::BeIdle: if (!empty_i) state_d = vrt_pkg::BeRun;
      vrt_pkg::BeRun:  if (fire && !(cont && next_cont)) state_d = vrt_pkg::BeIdle;
      default:         state_d = vrt_pkg::BeIdle;
    endcase
  end

  // outputs
  always_comb begin
    pop_o = (state_q == vrt_pkg::BeIdle) && !empty_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vrt_pkg::BeIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        ovalid_q <= 1'b1;
      end else if (vox.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int a = 0; a < 3; a++) begin
        axis_q[a] <= axes_i[a];
        cpos_q[a] <= cells_i[a*COORD_BITS +: COORD_BITS];
      end
      n_q <= '0;
    end else if (fire) begin
      if (cont) begin
        cpos_q[sel]      <= cnew[sel];
        axis_q[sel].tmax <= tnew;
        n_q              <= n_q + CntW'(1);
        for (int a = 0; a < 3; a++) begin
          ocell_q[a] <= cext[a][15:0];
          onorm_q[a] <= vrt_pkg::StepZero;
        end
        onorm_q[sel] <= (axis_q[sel].step == vrt_pkg::StepPos) ? vrt_pkg::StepNeg
                                                                : vrt_pkg::StepPos;
        ocv_q   <= 1'b1;
        olast_q <= !next_cont;
      end else begin
        // nothing entered: one empty transaction
        for (int a = 0; a < 3; a++) begin
          ocell_q[a] <= '0;
          onorm_q[a] <= vrt_pkg::StepZero;
        end
        ocv_q   <= 1'b0;
        olast_q <= 1'b1;
      end
    end
  end

  assign vox.valid      = ovalid_q;
  assign vox.cell_x     = ocell_q[0];
  assign vox.cell_y     = ocell_q[1];
  assign vox.cell_z     = ocell_q[2];
  assign vox.normal_x   = onorm_q[0];
  assign vox.normal_y   = onorm_q[1];
  assign vox.normal_z   = onorm_q[2];
  assign vox.cell_valid = ocv_q;
  assign vox.last       = olast_q;
endmodule

>>> rtl/voxel_ray_traversal_top.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_top
// Grid traversal of one ray: set-up front, two-entry queue, stepping engine.
// ----------------------------------------------------------------------------
// path: ray accept, square, sum, serial square root, multiply, dividers, queue
//   push, engine pop, output register; the front takes a new ray only once
//   idle again, the queue lets it set up a ray while the engine steps, and
//   the engine gives one cell a cycle while the output is not stalled
// reset: radius 6, queue and output empty, no clearing pass
module voxel_ray_traversal_top #(
  parameter int unsigned MAX_STEPS  = 32,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  vrt_ray_if.sink                    ray,
  vrt_cell_if.source                 vox,
  input  logic                       cfg_we_i,
  input  logic [vrt_pkg::RadW-1:0]   cfg_wdata_i
);
  localparam int unsigned QW = 3 * $bits(vrt_pkg::axis_t) + 3 * COORD_BITS;

  logic [vrt_pkg::RadW-1:0]    radius_q;
  vrt_pkg::axis_t [2:0]        fe_axes, be_axes;
  logic [3*COORD_BITS-1:0]     fe_cells, be_cells;
  logic                        q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= vrt_pkg::RadReset;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  vrt_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ray     (ray),
    .axes_o  (fe_axes),
    .cells_o (fe_cells),
    .push_o  (q_push),
    .full_i  (q_full)
  );

  vrt_queue #(.W(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({fe_axes, fe_cells}),
    .pop_i   (q_pop),
    .data_o  ({be_axes, be_cells}),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  vrt_back #(.COORD_BITS(COORD_BITS), .MAX_STEPS(MAX_STEPS)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .axes_i   (be_axes),
    .cells_i  (be_cells),
    .empty_i  (q_empty),
    .pop_o    (q_pop),
    .radius_i (radius_q),
    .vox      (vox)
  );

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("set-up queue overflow");

  a_queue_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("set-up queue underflow");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vox.valid && !vox.cell_valid |-> vox.last)
    else $error("empty traversal transaction without last");

  a_one_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vox.valid && vox.cell_valid |->
      $countones({vox.normal_x != 2'sb00, vox.normal_y != 2'sb00,
                  vox.normal_z != 2'sb00}) == 1)
    else $error("entered cell must carry exactly one face normal");
endmodule

>>> tb/ray_channels.sv
// ----------------------------------------------------------------------------
// ray_channels
// Test harness channel helpers: none needed beyond the rtl interfaces.
// ----------------------------------------------------------------------------
package ray_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [23:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
  } ray_t;

  typedef struct {
    logic signed [15:0] cx, cy, cz;
    logic signed [1:0]  nx, ny, nz;
    logic               cv, lst;
  } hit_t;
endpackage

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// voxel ray traversal testbench
// Drives rays through the valid/ready input, predicts the cells each ray
// enters and checks every cell transaction in order, over several radius
// settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vrt_pkg::*;
  import ray_tb_pkg::*;

  logic clk_i, rst_ni, cfg_we_i;
  logic [RadW-1:0] cfg_wdata_i;
  vrt_ray_if  ray ();
  vrt_cell_if vox ();

  voxel_ray_traversal_top i_dut (
    .clk_i, .rst_ni, .ray(ray.sink), .vox(vox.source), .cfg_we_i, .cfg_wdata_i
  );

  hit_t cells_due[$];
  logic [RadW-1:0] radius;
  int   errors = 0;
  int   src_idle = 0, snk_stall = 0;
  int   hold_off = 0;
  longint cycle = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [23:0] sat24(logic [63:0] v);
    return v > 64'hFFFFFF ? 24'hFFFFFF : v[23:0];
  endfunction

  // walks the grid for one ray and queues the cells it enters, or one empty transaction if it enters none
  task automatic predict_cells(ray_t r);
    longint d[3], o[3];
    logic [15:0] c[3];
    logic [23:0] tm[3], td[3];
    int stp[3];
    logic [63:0] s, len, ad, span, fr;
    logic [23:0] rad;
    int a, n;
    hit_t h;
    d = '{r.dx, r.dy, r.dz};
    o = '{r.ox, r.oy, r.oz};
    s = 0;
    for (int k = 0; k < 3; k++) s += d[k] * d[k];
    len = isqrt(s << 28);
    rad = {3'd0, radius, 16'd0};
    for (int k = 0; k < 3; k++) begin
      fr = o[k] & 255;
      c[k] = 16'((o[k] - longint'(fr)) >>> 8);
      if (d[k] == 0) begin
        stp[k] = 0; tm[k] = TSat; td[k] = TSat;
      end else begin
        ad = d[k] < 0 ? -d[k] : d[k];
        if (d[k] > 0) begin
          stp[k] = 1; span = fr == 0 ? 256 : 256 - fr;
        end else begin
          stp[k] = -1; span = fr;
        end
        td[k] = sat24((4 * len) / ad);
        tm[k] = sat24((span * len) / (ad * 64));
      end
    end
    n = 0;
    while (n < 32 && (tm[0] <= rad || tm[1] <= rad || tm[2] <= rad)) begin
      if (tm[0] < tm[1]) a = tm[0] < tm[2] ? 0 : 2;
      else a = tm[1] < tm[2] ? 1 : 2;
      c[a] = stp[a] > 0 ? c[a] + 16'd1 : c[a] - 16'd1;
      tm[a] = sat24(64'(tm[a]) + td[a]);
      h = '{c[0], c[1], c[2], 2'sd0, 2'sd0, 2'sd0, 1'b1, 1'b0};
      if (a == 0) h.nx = stp[a] > 0 ? 2'sb11 : 2'sb01;
      if (a == 1) h.ny = stp[a] > 0 ? 2'sb11 : 2'sb01;
      if (a == 2) h.nz = stp[a] > 0 ? 2'sb11 : 2'sb01;
      cells_due.insert(cells_due.size(), h);
      n++;
    end
    if (n == 0) begin
      h = '{16'sd0, 16'sd0, 16'sd0, 2'sd0, 2'sd0, 2'sd0, 1'b0, 1'b1};
      cells_due.insert(cells_due.size(), h);
    end else begin
      cells_due[$].lst = 1'b1;
    end
  endtask

  // directed rays; typed rows carry their one expected transaction in h
  typedef struct {
    ray_t r;
    bit   typed;
    hit_t h;
  } row_t;

  row_t rows[$];

  function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_t r;
    r = '{24'(ox), 24'(oy), 24'(oz), 16'(dx), 16'(dy), 16'(dz)};
    return r;
  endfunction

  function automatic void add_row(ray_t r, bit typed, hit_t h);
    row_t w;
    w = '{r, typed, h};
    rows.insert(rows.size(), w);
  endfunction

  initial begin
    hit_t none;
    none = '{16'sd0, 16'sd0, 16'sd0, 2'sd0, 2'sd0, 2'sd0, 1'b0, 1'b1};
    add_row(mk(0, 0, 0, 0, 0, 0), 1, none);
    // steps along +x from origin: cells (1,0,0) to (6,0,0), each face -x
    add_row(mk(0, 0, 0, 16384, 0, 0), 0, none);
    add_row(mk(0, 0, 0, -16384, 0, 0), 0, none);
    add_row(mk(128, 128, 128, 0, 16384, 0), 0, none);
    add_row(mk(0, 0, 0, 0, 0, -32768), 0, none);
    add_row(mk(8388607, 8388607, 8388607, 32767, 32767, 32767), 0, none);
    add_row(mk(-8388608, -8388608, -8388608, -32768, -32768, -32768), 0, none);
    add_row(mk(-8388608, 8388607, 0, 1, -1, 0), 0, none);
    add_row(mk(255, -1, 1, 0, 0, 1), 0, none);
    add_row(mk(0, 0, 0, 16384, 16384, 16384), 0, none);
    add_row(mk(0, 0, 0, 16384, 16384, 0), 0, none);
    add_row(mk(300, 700, -900, 1000, -20000, 3), 0, none);
    add_row(mk(5, 9, 250, 32767, 1, 1), 0, none);
    add_row(mk(0, 0, 0, 1, 0, 0), 0, none);
  end

  // sink with random stalls and a counted hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      vox.ready <= 1'b0;
    end else begin
      vox.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > 3000000) begin
      $display("status: fail");
      $finish;
    end
    if (rst_ni && vox.valid && vox.ready) begin
      if (cells_due.size() == 0) begin
        $error("cell transaction with nothing expected");
        errors++;
      end else begin
        hit_t e;
        e = cells_due.pop_front();
        if (vox.cell_x !== e.cx) begin
          $error("cell_x exp %0d got %0d", e.cx, vox.cell_x); errors++;
        end
        if (vox.cell_y !== e.cy) begin
          $error("cell_y exp %0d got %0d", e.cy, vox.cell_y); errors++;
        end
        if (vox.cell_z !== e.cz) begin
          $error("cell_z exp %0d got %0d", e.cz, vox.cell_z); errors++;
        end
        if (vox.normal_x !== e.nx) begin
          $error("normal_x exp %0d got %0d", e.nx, vox.normal_x); errors++;
        end
        if (vox.normal_y !== e.ny) begin
          $error("normal_y exp %0d got %0d", e.ny, vox.normal_y); errors++;
        end
        if (vox.normal_z !== e.nz) begin
          $error("normal_z exp %0d got %0d", e.nz, vox.normal_z); errors++;
        end
        if (vox.cell_valid !== e.cv) begin
          $error("cell_valid exp %0d got %0d", e.cv, vox.cell_valid); errors++;
        end
        if (vox.last !== e.lst) begin
          $error("last exp %0d got %0d", e.lst, vox.last); errors++;
        end
      end
    end
  end

  // valid stays up across back-to-back rays, drops only while idling
  task automatic send_ray(ray_t r);
    while ($urandom_range(99) < src_idle) begin
      ray.valid <= 1'b0;
      @(negedge clk_i);
    end
    ray.valid <= 1'b1;
    {ray.origin_x, ray.origin_y, ray.origin_z} <= {r.ox, r.oy, r.oz};
    {ray.dir_x, ray.dir_y, ray.dir_z} <= {r.dx, r.dy, r.dz};
    do @(posedge clk_i); while (!ray.ready);
    predict_cells(r);
    @(negedge clk_i);
  endtask

  task automatic drain;
    ray.valid <= 1'b0;
    while (cells_due.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic set_radius(logic [RadW-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    radius = v;
  endtask

  function automatic ray_t rand_ray();
    ray_t r;
    int m;
    m = int'($urandom_range(3));
    r.ox = 24'($urandom); r.oy = 24'($urandom); r.oz = 24'($urandom);
    r.dx = 16'($urandom); r.dy = 16'($urandom); r.dz = 16'($urandom);
    // some rays with zero dx, integer x/y origins or a zero direction, for ties and zero components
    if (m == 0) r.dx = 16'sd0;
    if (m == 1) begin
      r.ox[7:0] = 8'd0; r.oy[7:0] = 8'd0;
    end
    if ($urandom_range(19) == 0) {r.dx, r.dy, r.dz} = '0;
    return r;
  endfunction

  initial begin
    ray_t r;
    int idle_mix[4][2];
    logic [RadW-1:0] radii[4];
    idle_mix = '{'{0, 0}, '{65, 0}, '{0, 65}, '{31, 31}};
    radii = '{5'd1, 5'd16, 5'd31, 5'd0};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    ray.valid = 1'b0;
    {ray.origin_x, ray.origin_y, ray.origin_z, ray.dir_x, ray.dir_y, ray.dir_z} = '0;
    vox.ready = 1'b0;
    radius = RadReset;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      send_ray(rows[i].r);
      if (rows[i].typed && (cells_due.size() != 1 || cells_due[0] != rows[i].h)) begin
        $error("directed row %0d prediction mismatch", i); errors++;
      end
    end
    // long hold-off so the queue fills and input stalls
    hold_off = 400;
    for (int i = 0; i < 5; i++) begin
      r = rand_ray();
      send_ray(r);
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_radius(radii[ph]);
      src_idle = idle_mix[ph][0];
      snk_stall = idle_mix[ph][1];
      for (int i = 0; i < 25; i++) send_ray(rand_ray());
    end
    src_idle = 0; snk_stall = 0;
    set_radius(5'd3);
    for (int i = 0; i < 5; i++) send_ray(rand_ray());
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
